FILE: src/drt_pkg.sv
// Shared types and constants of the dirty rectangle tracker.
package drt_pkg;

    typedef enum logic [2:0] {
        KIND_ADD   = 3'd0,
        KIND_START = 3'd1,
        KIND_END   = 3'd2,
        KIND_READ  = 3'd3,
        KIND_FORCE = 3'd4,
        KIND_SKIP  = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SCAN,
        ST_APPEND,
        ST_READ
    } t_state;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALWAYS_FULL   = 2'd2;

    localparam logic [12:0] RST_SCREEN_WIDTH  = 13'd640;
    localparam logic [12:0] RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [12:0] DEFAULT_SIZE      = 13'd8;

    localparam int CLIP_W = 18;
    localparam int AREA_SUM_W = 32;
    localparam int INDEX_CMP_W = 11;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [15:0] rect_x;
        logic signed [15:0] rect_y;
        logic signed [15:0] rect_w;
        logic signed [15:0] rect_h;
        logic [7:0]         entry_index;
        logic [15:0]        redraw_frames;
    } t_req;

    typedef struct packed {
        logic        entry_valid;
        logic [11:0] out_x;
        logic [11:0] out_y;
        logic [12:0] out_w;
        logic [12:0] out_h;
        logic [7:0]  rect_count;
        logic        full_redraw;
        logic        skip_frame;
    } t_result;

endpackage

FILE: src/drt_clip.sv
// Clips a requested rectangle to the screen and flags empty results.
module drt_clip #(
    parameter int COORD_BITS = 13
) (
    input  drt_pkg::t_req           i_req,
    input  logic [COORD_BITS-1:0]   i_sw,
    input  logic [COORD_BITS-1:0]   i_sh,
    output logic                    o_keep,
    output logic [COORD_BITS-2:0]   o_x,
    output logic [COORD_BITS-2:0]   o_y,
    output logic [COORD_BITS-1:0]   o_w,
    output logic [COORD_BITS-1:0]   o_h
);
    import drt_pkg::*;

    logic signed [CLIP_W-1:0] x_s, y_s, w_s, h_s, sw_s, sh_s;
    logic signed [CLIP_W-1:0] ex, ey, left, top, right, bottom, cw, ch;

    assign x_s  = CLIP_W'($signed(i_req.rect_x));
    assign y_s  = CLIP_W'($signed(i_req.rect_y));
    assign w_s  = CLIP_W'($signed(i_req.rect_w));
    assign h_s  = CLIP_W'($signed(i_req.rect_h));
    assign sw_s = $signed(CLIP_W'(i_sw));
    assign sh_s = $signed(CLIP_W'(i_sh));

    always_comb begin
        ex     = x_s + w_s;
        ey     = y_s + h_s;
        left   = (x_s < 0) ? '0 : x_s;
        top    = (y_s < 0) ? '0 : y_s;
        right  = (ex > sw_s) ? sw_s : ex;
        bottom = (ey > sh_s) ? sh_s : ey;
        cw     = right - left;
        ch     = bottom - top;
        o_keep = !((ex <= 0) || (ey <= 0) || (x_s >= sw_s) || (y_s >= sh_s) ||
                   (cw <= 0) || (ch <= 0));
        o_x    = left[COORD_BITS-2:0];
        o_y    = top[COORD_BITS-2:0];
        o_w    = cw[COORD_BITS-1:0];
        o_h    = ch[COORD_BITS-1:0];
    end

endmodule

FILE: src/dirty_rectangle_tracker.sv
// Top level of the dirty rectangle tracker with its rectangle memory and control.
// An add request is decoded, then scans the stored entries in order and ends at the first
// entry that contains it, or is appended once the scan finds none; an add that clips away
// or meets a full list ends in decode. A read then reads memory; others end in decode.
// One request is in work at a time; results are strobed for one cycle and cannot be stalled.
// Synchronous active-low reset clears the list and skip flags, sets full flags, not memory.
module dirty_rectangle_tracker #(
    parameter int MAX_RECTS  = 255,
    parameter int COORD_BITS = 13
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  drt_pkg::t_req                       i_req,
    output logic                                o_done,
    output drt_pkg::t_result                    o_result,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [drt_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [drt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import drt_pkg::*;

    localparam int AW         = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
    localparam int CW         = $clog2(MAX_RECTS + 1);
    localparam int XW         = COORD_BITS - 1;
    localparam int EW         = 2 * XW + 2 * COORD_BITS;
    localparam int SW         = COORD_BITS + 1;
    localparam int AREA_W     = 2 * COORD_BITS;
    localparam int SCREEN_MAX = 1 << (COORD_BITS - 1);

    t_state                  r_state, n_state;
    t_req                    r_req, n_req;
    logic [CFG_DATA_W-1:0]   r_screen_width, r_screen_height;
    logic                    r_always_full;
    logic [CW-1:0]           r_count, n_count;
    logic [AREA_SUM_W-1:0]   r_area_sum, n_area_sum;
    logic                    r_full, n_full;
    logic                    r_pend, n_pend;
    logic [15:0]             r_pend_frames, n_pend_frames;
    logic                    r_skip, n_skip;
    logic                    r_skipped, n_skipped;
    logic [XW-1:0]           r_cx, n_cx, r_cy, n_cy;
    logic [COORD_BITS-1:0]   r_cw, n_cw, r_ch, n_ch;
    logic [CW-1:0]           r_scan, n_scan;
    logic                    r_rd_vld, n_rd_vld;
    logic [EW-1:0]           r_rd_data;
    logic [AREA_W-1:0]       r_prod, r_scr_area;
    logic                    r_done, n_done;
    t_result                 r_out, n_out;
    logic [EW-1:0]           r_rect_mem [MAX_RECTS];

    logic [COORD_BITS-1:0]   sw, sh;
    logic                    clip_keep;
    logic [XW-1:0]           clip_x, clip_y;
    logic [COORD_BITS-1:0]   clip_w, clip_h;
    logic [XW-1:0]           b_x, b_y;
    logic [COORD_BITS-1:0]   b_w, b_h;
    logic                    hit, rd_en, wr_en, rd_ok, finish, from_mem;
    logic [AW-1:0]           rd_addr;
    logic [AREA_SUM_W:0]     sum_wide;
    logic [AREA_SUM_W-1:0]   sum_sat;

    assign sw = (32'(r_screen_width) > SCREEN_MAX) ? COORD_BITS'(SCREEN_MAX)
                                                   : COORD_BITS'(r_screen_width);
    assign sh = (32'(r_screen_height) > SCREEN_MAX) ? COORD_BITS'(SCREEN_MAX)
                                                    : COORD_BITS'(r_screen_height);

    drt_clip #(
        .COORD_BITS (COORD_BITS)
    ) u_clip (
        .i_req  (r_req),
        .i_sw   (sw),
        .i_sh   (sh),
        .o_keep (clip_keep),
        .o_x    (clip_x),
        .o_y    (clip_y),
        .o_w    (clip_w),
        .o_h    (clip_h)
    );

    assign b_x = r_rd_data[EW-1 -: XW];
    assign b_y = r_rd_data[EW-1-XW -: XW];
    assign b_w = r_rd_data[2*COORD_BITS-1 -: COORD_BITS];
    assign b_h = r_rd_data[COORD_BITS-1:0];

    assign hit = (r_cw <= b_w) && (r_ch <= b_h) && (r_cx >= b_x) && (r_cy >= b_y) &&
                 ((SW'(r_cx) + SW'(r_cw)) <= (SW'(b_x) + SW'(b_w))) &&
                 ((SW'(r_cy) + SW'(r_ch)) <= (SW'(b_y) + SW'(b_h)));

    assign rd_ok = (INDEX_CMP_W'(r_req.entry_index) < INDEX_CMP_W'(r_count)) &&
                   (INDEX_CMP_W'(r_req.entry_index) < INDEX_CMP_W'(MAX_RECTS));

    assign sum_wide = (AREA_SUM_W+1)'(r_area_sum) + (AREA_SUM_W+1)'(r_prod);
    assign sum_sat  = sum_wide[AREA_SUM_W] ? '1 : sum_wide[AREA_SUM_W-1:0];

    assign busy        = (r_state != ST_IDLE);
    assign o_done      = r_done;
    assign o_result    = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_count       = r_count;
        n_area_sum    = r_area_sum;
        n_full        = r_full;
        n_pend        = r_pend;
        n_pend_frames = r_pend_frames;
        n_skip        = r_skip;
        n_skipped     = r_skipped;
        n_cx          = r_cx;
        n_cy          = r_cy;
        n_cw          = r_cw;
        n_ch          = r_ch;
        n_scan        = r_scan;
        n_rd_vld      = 1'b0;
        n_done        = 1'b0;
        n_out         = r_out;
        rd_en         = 1'b0;
        rd_addr       = '0;
        wr_en         = 1'b0;
        finish        = 1'b0;
        from_mem      = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_req   = i_req;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (r_req.kind)
                    KIND_ADD: begin
                        if (r_count >= CW'(MAX_RECTS)) begin
                            n_full = 1'b1;
                            finish = 1'b1;
                        end else if (!clip_keep) begin
                            finish = 1'b1;
                        end else begin
                            n_cx    = clip_x;
                            n_cy    = clip_y;
                            n_cw    = clip_w;
                            n_ch    = clip_h;
                            n_scan  = '0;
                            n_state = ST_SCAN;
                        end
                    end
                    KIND_START: begin
                        n_count    = '0;
                        n_area_sum = '0;
                        n_pend     = 1'b0;
                        n_full     = r_pend || (r_pend_frames != '0) || r_always_full;
                        if (r_pend_frames != '0) begin
                            n_pend_frames = r_pend_frames - 16'd1;
                        end
                        finish = 1'b1;
                    end
                    KIND_END: begin
                        n_skipped = r_skipped || r_skip;
                        n_skip    = 1'b0;
                        finish    = 1'b1;
                    end
                    KIND_READ: begin
                        if (rd_ok) begin
                            rd_en   = 1'b1;
                            rd_addr = AW'(r_req.entry_index);
                            n_state = ST_READ;
                        end else begin
                            finish = 1'b1;
                        end
                    end
                    KIND_FORCE: begin
                        n_pend        = 1'b1;
                        n_pend_frames = r_req.redraw_frames;
                        n_full        = 1'b1;
                        n_skipped     = 1'b0;
                        n_skip        = 1'b0;
                        finish        = 1'b1;
                    end
                    KIND_SKIP: begin
                        if (r_full) begin
                            n_skip    = 1'b0;
                            n_skipped = 1'b0;
                        end else if (r_skipped) begin
                            n_skipped = 1'b0;
                        end else begin
                            n_skip = 1'b1;
                        end
                        finish = 1'b1;
                    end
                    default: begin
                        finish = 1'b1;
                    end
                endcase
            end
            ST_SCAN: begin
                if (r_rd_vld && hit) begin
                    finish = 1'b1;
                end else if (r_scan == r_count) begin
                    n_state = ST_APPEND;
                end else begin
                    rd_en    = 1'b1;
                    rd_addr  = r_scan[AW-1:0];
                    n_scan   = r_scan + CW'(1);
                    n_rd_vld = 1'b1;
                end
            end
            ST_APPEND: begin
                wr_en      = 1'b1;
                n_count    = r_count + CW'(1);
                n_area_sum = sum_sat;
                if (sum_sat >= AREA_SUM_W'(r_scr_area)) begin
                    n_full = 1'b1;
                end
                finish = 1'b1;
            end
            ST_READ: begin
                from_mem = 1'b1;
                finish   = 1'b1;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        if (finish) begin
            n_state           = ST_IDLE;
            n_done            = 1'b1;
            n_out.entry_valid = from_mem;
            n_out.out_x       = from_mem ? 12'(b_x) : '0;
            n_out.out_y       = from_mem ? 12'(b_y) : '0;
            n_out.out_w       = from_mem ? 13'(b_w) : DEFAULT_SIZE;
            n_out.out_h       = from_mem ? 13'(b_h) : DEFAULT_SIZE;
            n_out.rect_count  = 8'(n_count);
            n_out.full_redraw = n_full || r_always_full;
            n_out.skip_frame  = n_skip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_count       <= '0;
            r_area_sum    <= '0;
            r_full        <= 1'b1;
            r_pend        <= 1'b1;
            r_pend_frames <= '0;
            r_skip        <= 1'b0;
            r_skipped     <= 1'b0;
            r_scan        <= '0;
            r_rd_vld      <= 1'b0;
            r_done        <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_count       <= n_count;
            r_area_sum    <= n_area_sum;
            r_full        <= n_full;
            r_pend        <= n_pend;
            r_pend_frames <= n_pend_frames;
            r_skip        <= n_skip;
            r_skipped     <= n_skipped;
            r_scan        <= n_scan;
            r_rd_vld      <= n_rd_vld;
            r_done        <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req      <= n_req;
        r_cx       <= n_cx;
        r_cy       <= n_cy;
        r_cw       <= n_cw;
        r_ch       <= n_ch;
        r_out      <= n_out;
        r_prod     <= r_cw * r_ch;
        r_scr_area <= sw * sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= RST_SCREEN_WIDTH;
            r_screen_height <= RST_SCREEN_HEIGHT;
            r_always_full   <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SCREEN_WIDTH:  r_screen_width  <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data;
                CFG_ALWAYS_FULL:   r_always_full   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_rect_mem[r_count[AW-1:0]] <= {r_cx, r_cy, r_cw, r_ch};
        end
        if (rd_en) begin
            r_rd_data <= r_rect_mem[rd_addr];
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_RECTS))
        else $error("stored count above the list limit");

    a_append_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_APPEND) |-> (r_count < CW'(MAX_RECTS)))
        else $error("append with a full list");

    a_done_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != ST_IDLE))
        else $error("result strobe without a request in work");

    a_valid_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.entry_valid) |-> ($past(r_state) == ST_READ))
        else $error("valid entry returned outside a read");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

endmodule
